### rtl/upe_pkg.sv
`default_nettype none

package upe_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned TOKENS_MAX = 4;
   localparam int unsigned HELD_MAX = 3;
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 64;

   localparam logic [1:0] REG_ALLOW_MULTIBYTE = 2'd0;
   localparam logic [1:0] REG_EXTRA_LOW = 2'd1;
   localparam logic [1:0] REG_EXTRA_HIGH = 2'd2;

   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_DASH = 8'h2d;
   localparam logic [7:0] CHAR_DOT = 8'h2e;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CHAR_TILDE = 8'h7e;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       string_end;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] tok_byte;
      logic       escape;
      logic       run_end;
      logic       string_end;
   } token_type;

   typedef struct packed {
      logic        allow_multibyte;
      logic [63:0] extra_allowed_low;
      logic [63:0] extra_allowed_high;
   } cfg_type;

   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] len;
      len = 3'd1;
      if (b >= 8'hc2 && b <= 8'hdf) len = 3'd2;
      else if (b >= 8'he0 && b <= 8'hef) len = 3'd3;
      else if (b >= 8'hf0 && b <= 8'hf4) len = 3'd4;
      return len;
   endfunction

   function automatic logic next_ok(input logic [7:0] lead, input logic [1:0] pos,
                                    input logic [7:0] b);
      logic [7:0] lo;
      logic [7:0] hi;
      lo = 8'h80;
      hi = 8'hbf;
      if (pos == 2'd1) begin
         if (lead == 8'he0) lo = 8'ha0;
         else if (lead == 8'hed) hi = 8'h9f;
         else if (lead == 8'hf0) lo = 8'h90;
         else if (lead == 8'hf4) hi = 8'h8f;
      end
      return (b >= lo) && (b <= hi);
   endfunction

   function automatic logic ascii_passes(input logic [7:0] b, input logic [63:0] mask_low,
                                         input logic [63:0] mask_high);
      logic pass;
      pass = 1'b0;
      if ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
          (b >= 8'h61 && b <= 8'h7a) || b == CHAR_DASH || b == CHAR_DOT ||
          b == CHAR_UNDERSCORE || b == CHAR_TILDE) begin
         pass = 1'b1;
      end else if (!b[7]) begin
         pass = b[6] ? mask_high[b[5:0]] : mask_low[b[5:0]];
      end
      return pass;
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] nibble);
      logic [7:0] digit;
      if (nibble < 4'd10) digit = CHAR_ZERO + {4'd0, nibble};
      else digit = CHAR_UPPER_A + {4'd0, nibble} - 8'd10;
      return digit;
   endfunction

endpackage

`default_nettype wire

### rtl/uri_percent_encoder.sv
// Percent-encoder for URI text, one string byte per request with a flag on the last
// byte. The front stage classifies each byte, tracks pending UTF-8 sequences and turns
// a request into up to four tokens (raw or escaped byte) at one token per cycle while
// the token queue has room; the queue feeds the back stage, which drives one result byte
// per cycle while results are popped. A raw byte yields one result byte and an escaped
// byte three (a percent sign and two hex digits), so the single-byte result port sets
// the pace. A request that only holds a byte produces no result. Registers sit
// at byte addresses 0, 8 and 16 of the 64-bit configuration port.
`default_nettype none

module uri_percent_encoder #(
   parameter int unsigned QueueDepth = upe_pkg::QUEUE_DEPTH
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_push,
   input  upe_pkg::req_payload_type             req_payload,
   output logic                                 req_full,
   output logic                                 rsp_empty,
   input  wire                                  rsp_pop,
   output upe_pkg::rsp_payload_type             rsp_payload,
   input  wire                                  csr_psel,
   input  wire                                  csr_penable,
   input  wire                                  csr_pwrite,
   input  wire [upe_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  wire [upe_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [upe_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                 csr_pready
);

   logic        allow_ff, allow_in;
   logic [63:0] low_ff, low_in;
   logic [63:0] high_ff, high_in;
   logic [1:0]  reg_index;
   logic        csr_write;
   upe_pkg::cfg_type cfg;

   logic q_push, q_full, q_pop, q_empty;
   upe_pkg::token_type q_wdata, q_rdata;

   assign csr_pready = 1'b1;
   assign reg_index = csr_paddr[4:3];
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      allow_in = allow_ff;
      low_in = low_ff;
      high_in = high_ff;
      csr_prdata = '0;
      unique case (reg_index)
         upe_pkg::REG_ALLOW_MULTIBYTE: begin
            csr_prdata = {63'd0, allow_ff};
            if (csr_write) allow_in = csr_pwdata[0];
         end
         upe_pkg::REG_EXTRA_LOW: begin
            csr_prdata = low_ff;
            if (csr_write) low_in = csr_pwdata;
         end
         upe_pkg::REG_EXTRA_HIGH: begin
            csr_prdata = high_ff;
            if (csr_write) high_in = csr_pwdata;
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         allow_ff <= 1'b0;
         low_ff <= '0;
         high_ff <= '0;
      end else begin
         allow_ff <= allow_in;
         low_ff <= low_in;
         high_ff <= high_in;
      end
   end

   assign cfg.allow_multibyte = allow_ff;
   assign cfg.extra_allowed_low = low_ff;
   assign cfg.extra_allowed_high = high_ff;

   upe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_push    (req_push),
      .req_payload (req_payload),
      .req_full    (req_full),
      .tok_push    (q_push),
      .tok_data    (q_wdata),
      .tok_full    (q_full)
   );

   upe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   upe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .tok_data    (q_rdata),
      .tok_empty   (q_empty),
      .tok_pop     (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload)
   );

`ifndef ASSERT_OFF
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("token pushed into full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("token popped from empty queue");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> rsp_empty) else $error("result pending right after reset");

   a_token_needs_result: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> !rsp_empty) else $error("token retired without a result");
`endif

endmodule

`default_nettype wire

### rtl/upe_queue.sv
`default_nettype none

module upe_queue #(
   parameter int unsigned Depth = upe_pkg::QUEUE_DEPTH
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  upe_pkg::token_type  push_data,
   output logic                full,
   input  wire                 pop,
   output upe_pkg::token_type  pop_data,
   output logic                empty
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   upe_pkg::token_type mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign full = (count_ff == CntW'(Depth));
   assign empty = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) count_in = count_ff + CntW'(1);
      else if (pop && !push) count_in = count_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

### rtl/upe_front.sv
`default_nettype none

module upe_front (
   input  wire                      clock,
   input  wire                      reset,
   input  upe_pkg::cfg_type         cfg,
   input  wire                      req_push,
   input  upe_pkg::req_payload_type req_payload,
   output logic                     req_full,
   output logic                     tok_push,
   output upe_pkg::token_type       tok_data,
   input  wire                      tok_full
);

   upe_pkg::token_type tok_ff [upe_pkg::TOKENS_MAX];
   upe_pkg::token_type tok_in [upe_pkg::TOKENS_MAX];
   upe_pkg::token_type tk [upe_pkg::TOKENS_MAX];
   logic [2:0] left_ff, left_in;
   logic [7:0] held_ff [upe_pkg::HELD_MAX];
   logic [7:0] held_in [upe_pkg::HELD_MAX];
   logic [7:0] nh [upe_pkg::HELD_MAX];
   logic [1:0] cnt_ff, cnt_in, nc;
   logic [2:0] len_ff, len_in, nl;
   logic [2:0] nt;
   logic [2:0] ln;
   logic       handled;
   logic       accept;
   logic [7:0] b;
   logic       last;

   assign b = req_payload.in_byte;
   assign last = req_payload.in_last;
   assign req_full = (left_ff > 3'd1) || ((left_ff == 3'd1) && tok_full);
   assign accept = req_push && !req_full;
   assign tok_push = (left_ff != 3'd0) && !tok_full;
   assign tok_data = tok_ff[0];

   // classify the request and build its token list
   always_comb begin
      for (int j = 0; j < upe_pkg::TOKENS_MAX; j++) tk[j] = '0;
      for (int j = 0; j < upe_pkg::HELD_MAX; j++) nh[j] = held_ff[j];
      nt = 3'd0;
      nc = cnt_ff;
      nl = len_ff;
      handled = 1'b0;
      ln = upe_pkg::lead_length(b);
      if (cnt_ff != 2'd0) begin
         if (upe_pkg::next_ok(held_ff[0], cnt_ff, b)) begin
            handled = 1'b1;
            if ({1'b0, cnt_ff} + 3'd1 >= len_ff) begin
               for (int i = 0; i < upe_pkg::HELD_MAX; i++) begin
                  if (2'(i) < cnt_ff) begin
                     tk[nt[1:0]].tok_byte = held_ff[i];
                     nt = nt + 3'd1;
                  end
               end
               tk[nt[1:0]].tok_byte = b;
               nt = nt + 3'd1;
               nc = 2'd0;
               nl = 3'd0;
            end else begin
               nh[cnt_ff] = b;
               nc = cnt_ff + 2'd1;
            end
         end else begin
            for (int i = 0; i < upe_pkg::HELD_MAX; i++) begin
               if (2'(i) < cnt_ff) begin
                  tk[nt[1:0]].tok_byte = held_ff[i];
                  tk[nt[1:0]].escape = 1'b1;
                  nt = nt + 3'd1;
               end
            end
            nc = 2'd0;
            nl = 3'd0;
         end
      end
      if (!handled) begin
         if (cfg.allow_multibyte && ln >= 3'd2) begin
            nh[0] = b;
            nc = 2'd1;
            nl = ln;
         end else begin
            tk[nt[1:0]].tok_byte = b;
            tk[nt[1:0]].escape = !upe_pkg::ascii_passes(b, cfg.extra_allowed_low,
                                                         cfg.extra_allowed_high);
            nt = nt + 3'd1;
         end
      end
      // string ends mid-sequence
      if (last && nc != 2'd0) begin
         for (int i = 0; i < upe_pkg::HELD_MAX; i++) begin
            if (2'(i) < nc) begin
               tk[nt[1:0]].tok_byte = nh[i];
               tk[nt[1:0]].escape = 1'b1;
               nt = nt + 3'd1;
            end
         end
         nc = 2'd0;
         nl = 3'd0;
      end
      for (int j = 0; j < upe_pkg::TOKENS_MAX; j++) begin
         tk[j].run_end = (3'(j) + 3'd1 == nt);
         tk[j].string_end = (3'(j) + 3'd1 == nt) && last;
      end
   end

   always_comb begin
      for (int j = 0; j < upe_pkg::TOKENS_MAX; j++) tok_in[j] = tok_ff[j];
      for (int j = 0; j < upe_pkg::HELD_MAX; j++) held_in[j] = held_ff[j];
      left_in = left_ff;
      cnt_in = cnt_ff;
      len_in = len_ff;
      if (accept) begin
         for (int j = 0; j < upe_pkg::TOKENS_MAX; j++) tok_in[j] = tk[j];
         for (int j = 0; j < upe_pkg::HELD_MAX; j++) held_in[j] = nh[j];
         left_in = nt;
         cnt_in = nc;
         len_in = nl;
      end else if (tok_push) begin
         for (int j = 0; j < upe_pkg::TOKENS_MAX - 1; j++) tok_in[j] = tok_ff[j + 1];
         left_in = left_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < upe_pkg::TOKENS_MAX; j++) tok_ff[j] <= tok_in[j];
      for (int j = 0; j < upe_pkg::HELD_MAX; j++) held_ff[j] <= held_in[j];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 3'd0;
         cnt_ff <= 2'd0;
         len_ff <= 3'd0;
      end else begin
         left_ff <= left_in;
         cnt_ff <= cnt_in;
         len_ff <= len_in;
      end
   end

endmodule

`default_nettype wire

### rtl/upe_back.sv
`default_nettype none

module upe_back (
   input  wire                      clock,
   input  wire                      reset,
   input  upe_pkg::token_type       tok_data,
   input  wire                      tok_empty,
   output logic                     tok_pop,
   output logic                     rsp_empty,
   input  wire                      rsp_pop,
   output upe_pkg::rsp_payload_type rsp_payload
);

   typedef enum logic [2:0] {
      ST_FIRST = 3'b001,
      ST_HI    = 3'b010,
      ST_LO    = 3'b100
   } phase_type;

   phase_type phase_ff, phase_in;
   logic valid_ff, valid_in;
   upe_pkg::rsp_payload_type out_ff, out_in;
   logic load;
   logic final_byte;
   logic [7:0] next_byte;

   assign load = !tok_empty && (!valid_ff || rsp_pop);
   assign tok_pop = load && final_byte;
   assign rsp_empty = !valid_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      next_byte = tok_data.tok_byte;
      final_byte = 1'b1;
      phase_in = phase_ff;
      if (tok_data.escape) begin
         unique case (phase_ff)
            ST_FIRST: begin
               next_byte = upe_pkg::CHAR_PERCENT;
               final_byte = 1'b0;
               phase_in = ST_HI;
            end
            ST_HI: begin
               next_byte = upe_pkg::hex_digit(tok_data.tok_byte[7:4]);
               final_byte = 1'b0;
               phase_in = ST_LO;
            end
            ST_LO: begin
               next_byte = upe_pkg::hex_digit(tok_data.tok_byte[3:0]);
               phase_in = ST_FIRST;
            end
            default: begin
               phase_in = ST_FIRST;
            end
         endcase
      end
      if (!load) phase_in = phase_ff;
   end

   always_comb begin
      out_in = out_ff;
      valid_in = valid_ff;
      if (load) begin
         out_in.out_byte = next_byte;
         out_in.run_end = tok_data.run_end && final_byte;
         out_in.string_end = tok_data.string_end && final_byte;
         valid_in = 1'b1;
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ST_FIRST;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

### test/uri_percent_encoder_tb.sv
`timescale 1ns / 1ps

module uri_percent_encoder_tb;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned RSP_HOLD_CYCLES = 300;
   localparam int unsigned PHASE_REQUESTS = 67;
   localparam int unsigned RANDOM_PHASES = 6;

   class uri_escape_scoreboard;
      bit                       multibyte_on;
      bit [63:0]                pass_mask_low;
      bit [63:0]                pass_mask_high;
      bit [7:0]                 held_seq[3];
      int unsigned              held_count;
      int unsigned              seq_total;
      bit [7:0]                 run_bytes[$];
      upe_pkg::rsp_payload_type expected_bytes[$];
      int unsigned              failures;
      int unsigned              requests;
      int unsigned              results;
      string                    hex_chars = "0123456789ABCDEF";

      function void set_register(logic [1:0] index, logic [63:0] value);
         case (index)
            upe_pkg::REG_ALLOW_MULTIBYTE: multibyte_on = value[0];
            upe_pkg::REG_EXTRA_LOW: pass_mask_low = value;
            upe_pkg::REG_EXTRA_HIGH: pass_mask_high = value;
            default: ;
         endcase
      endfunction

      function int unsigned utf8_length(bit [7:0] b);
         if (b >= 8'hc2 && b <= 8'hdf) return 2;
         if (b >= 8'he0 && b <= 8'hef) return 3;
         if (b >= 8'hf0 && b <= 8'hf4) return 4;
         return 1;
      endfunction

      function bit continues_seq(bit [7:0] lead, int unsigned pos, bit [7:0] b);
         bit [7:0] lo;
         bit [7:0] hi;
         lo = 8'h80;
         hi = 8'hbf;
         if (pos == 1) begin
            case (lead)
               8'he0: lo = 8'ha0;
               8'hed: hi = 8'h9f;
               8'hf0: lo = 8'h90;
               8'hf4: hi = 8'h8f;
               default: ;
            endcase
         end
         return b >= lo && b <= hi;
      endfunction

      function bit passes_plain(bit [7:0] b);
         if ((b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
             b == "-" || b == "." || b == "_" || b == "~") begin
            return 1'b1;
         end
         if (b < 8'd64) return pass_mask_low[b[5:0]];
         if (b < 8'd128) return pass_mask_high[b[5:0]];
         return 1'b0;
      endfunction

      function void add_escaped(bit [7:0] b);
         run_bytes.push_back("%");
         run_bytes.push_back(hex_chars[b[7:4]]);
         run_bytes.push_back(hex_chars[b[3:0]]);
      endfunction

      function void escape_held();
         int unsigned i;
         for (i = 0; i < held_count; i++) add_escaped(held_seq[i]);
         held_count = 0;
         seq_total = 0;
      endfunction

      function void predict_request(bit [7:0] b, bit last);
         bit                       taken;
         int unsigned              i;
         int unsigned              len;
         upe_pkg::rsp_payload_type item;
         taken = 1'b0;
         run_bytes.delete();
         requests++;
         if (held_count > 0) begin
            if (continues_seq(held_seq[0], held_count, b)) begin
               taken = 1'b1;
               if (held_count + 1 >= seq_total) begin
                  for (i = 0; i < held_count; i++) run_bytes.push_back(held_seq[i]);
                  run_bytes.push_back(b);
                  held_count = 0;
                  seq_total = 0;
               end else begin
                  held_seq[held_count] = b;
                  held_count++;
               end
            end else begin
               escape_held();
            end
         end
         if (!taken) begin
            len = utf8_length(b);
            if (multibyte_on && len >= 2) begin
               held_seq[0] = b;
               held_count = 1;
               seq_total = len;
            end else if (passes_plain(b)) begin
               run_bytes.push_back(b);
            end else begin
               add_escaped(b);
            end
         end
         if (last && held_count > 0) escape_held();
         foreach (run_bytes[k]) begin
            item.out_byte = run_bytes[k];
            item.run_end = (k == run_bytes.size() - 1);
            item.string_end = last && (k == run_bytes.size() - 1);
            expected_bytes.push_back(item);
         end
      endfunction

      function void check_result(upe_pkg::rsp_payload_type got);
         upe_pkg::rsp_payload_type want;
         if (expected_bytes.size() == 0) begin
            $error("result byte %h with nothing expected", got.out_byte);
            failures++;
            return;
         end
         want = expected_bytes.pop_front();
         results++;
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
            failures++;
         end
         if (got.run_end !== want.run_end) begin
            $error("run_end: expected %b, got %b", want.run_end, got.run_end);
            failures++;
         end
         if (got.string_end !== want.string_end) begin
            $error("string_end: expected %b, got %b", want.string_end, got.string_end);
            failures++;
         end
      endfunction
   endclass

   logic                           clock;
   logic                           reset;
   logic                           req_push;
   upe_pkg::req_payload_type       req_payload;
   logic                           req_full;
   logic                           rsp_empty;
   logic                           rsp_pop;
   upe_pkg::rsp_payload_type       rsp_payload;
   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [upe_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [upe_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [upe_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   uri_escape_scoreboard sb = new();
   bit                   quiet = 1'b0;
   bit                   rsp_hold_request = 1'b0;
   int unsigned          requests_sent = 0;
   int unsigned          strings_sent = 0;
   int unsigned          settings_used = 0;
   int unsigned          cycle_count = 0;

   uri_percent_encoder i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_payload (req_payload),
      .req_full    (req_full),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side: random pop bursts plus one long hold on request
   initial begin
      int unsigned idle_left;
      int unsigned hold_left;
      idle_left = 0;
      hold_left = 0;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) sb.check_result(rsp_payload);
         if (reset) begin
            rsp_pop <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else if (rsp_hold_request) begin
            rsp_hold_request = 1'b0;
            hold_left = RSP_HOLD_CYCLES - 1;
            rsp_pop <= 1'b0;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_pop <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            idle_left = $urandom_range(1, 8) - 1;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // setup then access; the caller closes the transfer after the last write
   task automatic write_register(input logic [1:0] index, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_register(index, value);
   endtask

   task automatic program_registers(input bit multibyte, input logic [63:0] mask_low,
                                    input logic [63:0] mask_high);
      write_register(upe_pkg::REG_ALLOW_MULTIBYTE, {63'd0, multibyte});
      write_register(upe_pkg::REG_EXTRA_LOW, mask_low);
      write_register(upe_pkg::REG_EXTRA_HIGH, mask_high);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      settings_used++;
   endtask

   task automatic send_byte(input bit [7:0] b, input bit last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_push <= 1'b1;
      req_payload <= '{in_byte: b, in_last: last};
      do @(posedge clock); while (req_full);
      sb.predict_request(b, last);
      requests_sent++;
   endtask

   task automatic wait_idle();
      req_push <= 1'b0;
      while (sb.expected_bytes.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly well-formed text, with truncated sequences, stray continuations and noise
   task automatic send_random_string();
      bit [7:0]    text[$];
      bit [7:0]    seq[$];
      bit [7:0]    lo;
      bit [7:0]    hi;
      int unsigned len;
      int unsigned kind;
      repeat ($urandom_range(1, 6)) begin
         kind = $urandom_range(0, 9);
         if (kind <= 3) begin
            text.push_back(8'($urandom_range(1, 127)));
         end else if (kind <= 7) begin
            len = $urandom_range(2, 4);
            seq.delete();
            case (len)
               2: seq.push_back(8'($urandom_range(8'hc2, 8'hdf)));
               3: seq.push_back(8'($urandom_range(8'he0, 8'hef)));
               default: seq.push_back(8'($urandom_range(8'hf0, 8'hf4)));
            endcase
            lo = 8'h80;
            hi = 8'hbf;
            case (seq[0])
               8'he0: lo = 8'ha0;
               8'hed: hi = 8'h9f;
               8'hf0: lo = 8'h90;
               8'hf4: hi = 8'h8f;
               default: ;
            endcase
            seq.push_back(8'($urandom_range(lo, hi)));
            repeat (len - 2) seq.push_back(8'($urandom_range(8'h80, 8'hbf)));
            if (kind == 7) seq = seq[0:$urandom_range(0, len - 2)];
            text = {text, seq};
         end else if (kind == 8) begin
            text.push_back(8'($urandom_range(1, 255)));
         end else begin
            text.push_back(8'($urandom_range(8'h80, 8'hbf)));
         end
      end
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
      strings_sent++;
   endtask

   initial begin
      int unsigned phase_start;
      bit          multibyte;
      logic [63:0] mask_low;
      logic [63:0] mask_high;
      reset <= 1'b1;
      req_push <= 1'b0;
      req_payload <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      program_registers(1'b1, 64'd0, 64'd0);
      send_byte("A", 1'b0);
      send_byte("z", 1'b0);
      send_byte("0", 1'b0);
      send_byte("~", 1'b0);
      send_byte("-", 1'b0);
      send_byte(" ", 1'b0);
      send_byte(8'h7f, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hc3, 1'b0);
      send_byte(8'ha9, 1'b0);
      send_byte(8'he0, 1'b0);
      send_byte(8'ha0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hf4, 1'b0);
      send_byte(8'h8f, 1'b0);
      send_byte(8'hbf, 1'b0);
      send_byte(8'hbf, 1'b0);
      // broken sequence, new byte escaped on its own
      send_byte(8'hed, 1'b0);
      send_byte(8'ha0, 1'b0);
      // three held bytes broken by a new lead on the last byte
      send_byte(8'hf0, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hc3, 1'b1);
      // lead held across a mode change
      send_byte(8'hc3, 1'b0);
      wait_idle();
      program_registers(1'b0, '1, '1);
      send_byte(8'ha9, 1'b0);
      send_byte(" ", 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b1);
      wait_idle();
      strings_sent += 2;

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         multibyte = (p % 3 != 1);
         mask_low = {$urandom, $urandom};
         mask_high = {$urandom, $urandom};
         if (p == 2) begin
            mask_low = '1;
            mask_high = '1;
         end else if (p == 3) begin
            mask_low = '0;
            mask_high = '0;
         end
         program_registers(multibyte, mask_low, mask_high);
         quiet = (p == RANDOM_PHASES - 1);
         if (p == 1) rsp_hold_request = 1'b1;
         phase_start = requests_sent;
         while (requests_sent < phase_start + PHASE_REQUESTS) send_random_string();
         wait_idle();
      end

      $display("covered %0d requests in %0d strings across %0d register settings",
               sb.requests, strings_sent, settings_used);
      $display("%0d result bytes compared, including one %0d-cycle result hold",
               sb.results, RSP_HOLD_CYCLES);
      if (sb.failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/upe_pkg.sv
rtl/upe_queue.sv
rtl/upe_front.sv
rtl/upe_back.sv
rtl/uri_percent_encoder.sv
test/uri_percent_encoder_tb.sv
